// ----- rtl/core/dptv_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dptv_pkg
// Shared types and constants of the decaying partials tone voice: the layout
// of one partial's entry in the state memory and the per-partial constants.
// ============================================================================
package dptv_pkg;

    localparam int NUM_PARTIALS = 3;
    localparam int PART_AW      = 2;
    localparam int PHASE_W      = 32;
    localparam int LEVEL_W      = 24;
    localparam int PPH_W        = 36;
    localparam int FREQ_W       = 23;
    localparam int TAG_W        = 32;
    localparam int MIX_W        = 18;
    localparam int SINE_W       = 16;
    localparam int BASE_W       = 35;

    localparam logic [PPH_W-1:0]   PPH_RESET  = 36'd5864062015;
    localparam logic [LEVEL_W-1:0] LEVEL_STOP = 24'd8389;

    typedef logic [PART_AW-1:0] t_part_addr;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] step;
        logic [LEVEL_W-1:0] level;
    } t_partial;

    function automatic logic [LEVEL_W-1:0] start_level(input t_part_addr k);
        logic [LEVEL_W-1:0] v;
        unique case (k)
            2'd0:    v = 24'd8388608;
            2'd1:    v = 24'd5033165;
            2'd2:    v = 24'd3355443;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [LEVEL_W-1:0] decay_q24(input t_part_addr k);
        logic [LEVEL_W-1:0] v;
        unique case (k)
            2'd0:    v = 24'd16776377;
            2'd1:    v = 24'd16775874;
            2'd2:    v = 24'd16774699;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Ratios 1, 2.001 and 3.5 in Q16, written as shifts and adds.
    function automatic logic [PHASE_W-1:0] partial_step(input t_part_addr k,
                                                        input logic [BASE_W-1:0] base);
        logic [43:0] b;
        logic [43:0] v;
        b = 44'(base);
        unique case (k)
            2'd0:    v = b;
            2'd1:    v = (b << 1) + (((b << 6) + (b << 1)) >> 16);
            2'd2:    v = ((b << 3) - b) >> 1;
            default: v = '0;
        endcase
        return v[PHASE_W-1:0];
    endfunction

endpackage

// ----- rtl/core/dptv_sine_rom.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dptv_sine_rom
// Registered sine lookup. The first stage scales the phase
// to a table index, the second reads the table built at elaboration.
// ============================================================================
module dptv_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic [dptv_pkg::PHASE_W-1:0]  i_phase,
    output logic signed [dptv_pkg::SINE_W-1:0] o_sine
);
    import dptv_pkg::*;

    localparam int IdxW  = $clog2(SINE_TABLE_DEPTH);
    localparam int ProdW = PHASE_W + IdxW + 1;
    localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

    typedef logic signed [SINE_W-1:0] t_rom [SINE_TABLE_DEPTH];

    function automatic logic [63:0] quarter_sine(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = '0;
        end
        return unsigned'(sum);
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] t;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            t    = ((64'(i) << 32) / SINE_TABLE_DEPTH) & 64'hFFFF_FFFF;
            quad = t >> 30;
            r    = t & 64'h3FFF_FFFF;
            if (quad[0]) begin
                r = 64'h4000_0000 - r;
            end
            x = (r * HalfPiQ30) >> 30;
            s = quarter_sine(x);
            v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            rom[i] = (quad >= 64'd2) ? -signed'(v[SINE_W-1:0]) : signed'(v[SINE_W-1:0]);
        end
        return rom;
    endfunction

    localparam t_rom SineRom = build_rom();

    logic [ProdW-1:0] w_idx_prod;
    logic [IdxW-1:0]  r_idx;
    logic signed [SINE_W-1:0] r_sine;

    assign w_idx_prod = ProdW'(i_phase) * ProdW'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        r_idx  <= w_idx_prod[PHASE_W +: IdxW];
        r_sine <= SineRom[r_idx];
    end

    assign o_sine = r_sine;

endmodule

// ----- rtl/core/dptv_partial_mem.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dptv_partial_mem
// State memory of the partials: phase, step and level of each partial, one
// write port and one read port with registered read data.
// ============================================================================
module dptv_partial_mem (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  dptv_pkg::t_part_addr  i_rd_addr,
    output dptv_pkg::t_partial    o_rd_data,
    input  logic                  i_wr_en,
    input  dptv_pkg::t_part_addr  i_wr_addr,
    input  dptv_pkg::t_partial    i_wr_data
);
    import dptv_pkg::*;

    t_partial r_mem [NUM_PARTIALS];
    t_partial r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/decaying_partials_tone_voice_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// decaying_partials_tone_voice_core
// One-voice additive tone generator with three exponentially decaying
// partials kept in a small state memory.
//
//   Channel    Direction  Payload
//   s_axis     in         tuser: kind; tdata: frequency_q8, note_tag, mix_in
//   m_axis     out        tdata: mix_out, playing, current_tag
//   cfg        in         phase_per_hz, written with i_cfg_we
//
// A start request takes two partial products for the base step, forms the
// step from them and makes three memory writes. A tick while playing reads
// the memory, runs the registered sine lookup and multiply-accumulates over
// the three partials; a tick while silent passes mix_in through as the
// result. One request is in work at a time. A finished result waits in the
// output register; while it waits, the next result holds in the done state
// and no new request is taken. Reset is synchronous and clears the voice and
// the register to their start values.
// ============================================================================
module decaying_partials_tone_voice_core #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [35:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // frequency_q8, note_tag, mix_in, zero fill
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // mix_out, playing, current_tag, zero fill
);
    import dptv_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_BASE,
        ST_LOAD,
        ST_TICK,
        ST_DONE
    } t_state;

    localparam int PpW  = FREQ_W + 18;
    localparam int AccW = 43;
    localparam int ProdW = SINE_W + LEVEL_W + 1;
    localparam logic [AccW-1:0] RoundHalf = AccW'(1) << 22;
    localparam logic signed [20:0] MixMax = 21'sd131071;
    localparam logic signed [20:0] MixMin = -21'sd131072;

    t_state r_state;
    logic [2:0] r_cyc;
    logic [PPH_W-1:0] r_pph;
    logic [FREQ_W-1:0] r_freq;
    logic [TAG_W-1:0] r_tag_in;
    logic signed [MIX_W-1:0] r_mix;
    logic [PpW-1:0] r_pp_lo;
    logic [PpW-1:0] r_pp_hi;
    logic [BASE_W-1:0] r_base;
    logic [LEVEL_W-1:0] r_lvl_d1;
    logic [LEVEL_W-1:0] r_lvl_d2;
    logic signed [ProdW-1:0] r_prod;
    logic signed [AccW-1:0] r_acc;
    logic r_stop;
    logic r_active;
    logic [TAG_W-1:0] r_tag;
    logic signed [MIX_W-1:0] r_res;
    logic r_m_valid;
    logic signed [MIX_W-1:0] r_m_mix;
    logic r_m_play;
    logic [TAG_W-1:0] r_m_tag;

    logic w_accept;
    logic [17:0] w_pph_part;
    logic [PpW-1:0] w_pp;
    logic [PPH_W+FREQ_W-1:0] w_base_sum;
    logic w_rd_en;
    t_part_addr w_rd_addr;
    t_partial w_rd_data;
    logic w_wr_en;
    t_part_addr w_wr_addr;
    t_partial w_wr_data;
    t_part_addr w_tk_addr;
    logic [2*LEVEL_W-1:0] w_decay_prod;
    logic [LEVEL_W-1:0] w_new_level;
    logic signed [SINE_W-1:0] w_sine;
    logic signed [ProdW-1:0] w_prod;
    logic signed [AccW-1:0] w_acc_round;
    logic signed [20:0] w_sample;
    logic signed [20:0] w_mix_sum;
    logic signed [MIX_W-1:0] w_mix_sat;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    assign w_pph_part = (r_state == ST_MUL_LO) ? r_pph[17:0] : r_pph[35:18];
    assign w_pp       = PpW'(r_freq) * PpW'(w_pph_part);
    assign w_base_sum = (PPH_W+FREQ_W)'({r_pp_hi, 18'd0}) + (PPH_W+FREQ_W)'(r_pp_lo);

    assign w_rd_en   = (r_state == ST_TICK) && (r_cyc < 3'd3);
    assign w_rd_addr = r_cyc[PART_AW-1:0];
    assign w_tk_addr = PART_AW'(r_cyc - 3'd1);

    assign w_decay_prod = (2*LEVEL_W)'(w_rd_data.level) * (2*LEVEL_W)'(decay_q24(w_tk_addr));
    assign w_new_level  = w_decay_prod[2*LEVEL_W-1:LEVEL_W];

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cyc[PART_AW-1:0];
        w_wr_data = '{phase: '0, step: partial_step(r_cyc[PART_AW-1:0], r_base),
                      level: start_level(r_cyc[PART_AW-1:0])};
        if (r_state == ST_LOAD) begin
            w_wr_en = 1'b1;
        end else if ((r_state == ST_TICK) && (r_cyc >= 3'd1) && (r_cyc <= 3'd3)) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_tk_addr;
            w_wr_data = '{phase: w_rd_data.phase + w_rd_data.step,
                          step:  w_rd_data.step,
                          level: w_new_level};
        end
    end

    dptv_partial_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    dptv_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_phase (w_rd_data.phase),
        .o_sine  (w_sine)
    );

    assign w_prod      = ProdW'(w_sine) * signed'({1'b0, r_lvl_d2});
    assign w_acc_round = r_acc + signed'(RoundHalf);
    assign w_sample    = 21'(w_acc_round >>> 23);
    assign w_mix_sum   = 21'(r_mix) + w_sample;

    always_comb begin
        if (w_mix_sum > MixMax) begin
            w_mix_sat = MixMax[MIX_W-1:0];
        end else if (w_mix_sum < MixMin) begin
            w_mix_sat = MixMin[MIX_W-1:0];
        end else begin
            w_mix_sat = w_mix_sum[MIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl_d1 <= w_rd_data.level;
        r_lvl_d2 <= r_lvl_d1;
        r_prod   <= w_prod;
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cyc     <= '0;
            r_pph     <= PPH_RESET;
            r_active  <= 1'b0;
            r_tag     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pph <= i_cfg_wdata;
            end
            if (r_m_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_freq   <= s_axis_tdata[22:0];
                        r_tag_in <= s_axis_tdata[54:23];
                        r_mix    <= signed'(s_axis_tdata[72:55]);
                        r_cyc    <= '0;
                        r_acc    <= '0;
                        if (!s_axis_tuser) begin
                            r_state <= ST_MUL_LO;
                        end else if (!r_active) begin
                            r_res   <= signed'(s_axis_tdata[72:55]);
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_TICK;
                        end
                    end
                end
                ST_MUL_LO: begin
                    r_pp_lo <= w_pp;
                    r_state <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    r_pp_hi <= w_pp;
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    r_base  <= w_base_sum[24 +: BASE_W];
                    r_cyc   <= '0;
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_cyc <= r_cyc + 3'd1;
                    if (r_cyc == 3'd2) begin
                        r_active <= 1'b1;
                        r_tag    <= r_tag_in;
                        r_res    <= '0;
                        r_state  <= ST_DONE;
                    end
                end
                ST_TICK: begin
                    r_cyc <= r_cyc + 3'd1;
                    if (r_cyc == 3'd1) begin
                        r_stop <= (w_new_level < LEVEL_STOP);
                    end
                    if ((r_cyc >= 3'd4) && (r_cyc <= 3'd6)) begin
                        r_acc <= r_acc + AccW'(r_prod);
                    end
                    if (r_cyc == 3'd7) begin
                        r_res <= w_mix_sat;
                        if (r_stop) begin
                            r_active <= 1'b0;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_mix   <= r_res;
                        r_m_play  <= r_active;
                        r_m_tag   <= r_tag;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_tag, r_m_play, r_m_mix};

endmodule
